// File: rtl/fmbs_pkg.sv
package fmbs_pkg;

  localparam int BOUND_W = 22;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [1:0] CFG_TEXT_LENGTH = 2'd0;
  localparam logic [1:0] CFG_SENTINEL_POS = 2'd1;
  localparam logic [1:0] CFG_SENTINEL_CODE = 2'd2;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SEARCH = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [15:0] entry;
    logic [2:0]  sel;
    logic [31:0] data;
    logic [1:0]  code;
    logic        start;
    logic        last;
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SUM
  } back_state_t;

  typedef struct packed {
    logic busy;
    logic result_load;
  } back_stat_t;

  function automatic logic [5:0] popcount32(input logic [31:0] x);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(x[i]);
    end
    return n;
  endfunction

endpackage

// File: rtl/fmbs_front.sv
module fmbs_front import fmbs_pkg::*; #(
  parameter int ENTRIES = 65536,
  parameter int CHUNK = 64
) (
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // entry_index, word_select, word_data, symbol, query_start
  input  logic        s_tuser,  // func
  input  logic        s_tlast,  // query_end
  input  logic        q_full,
  output logic        push,
  output op_t         item
);

  localparam int ENTRY_WORDS = 2 * CHUNK / 32 + 4;

  logic [7:0] sym;
  logic       load_ok;

  always_comb begin
    sym = s_tdata[58:51];
    item.kind = op_kind_t'(s_tuser);
    item.entry = s_tdata[15:0];
    item.sel = s_tdata[18:16];
    item.data = s_tdata[50:19];
    // code bit 1 is ascii bit 2, code bit 0 is bit 1 xor bit 2
    item.code = {sym[2], sym[1] ^ sym[2]};
    item.start = s_tdata[59];
    item.last = s_tlast;
    load_ok = ({16'd0, item.entry} < 32'(ENTRIES)) && ({29'd0, item.sel} < 32'(ENTRY_WORDS));
  end

  // loads outside the store are taken and dropped
  assign s_tready = !q_full;
  assign push = s_tvalid && !q_full && ((item.kind == OP_SEARCH) || load_ok);

endmodule

// File: rtl/fmbs_queue.sv
module fmbs_queue import fmbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_item,
  output logic full,
  output logic valid,
  output op_t  head,
  input  logic pop
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/fmbs_back.sv
module fmbs_back import fmbs_pkg::*; #(
  parameter int ENTRIES = 65536,
  parameter int CHUNK = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [BOUND_W-1:0] cfg_data,
  input  logic               q_valid,
  input  op_t                q_head,
  output logic               q_pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [47:0]        m_tdata,
  output back_stat_t         stat
);

  localparam int PW = CHUNK / 32;
  localparam int EW = 2 * PW + 4;
  localparam int AW = $clog2(ENTRIES);
  localparam int CB = $clog2(CHUNK);

  back_state_t state, state_next;

  logic [BOUND_W-1:0] text_length;
  logic [BOUND_W-1:0] sentinel_position;
  logic [1:0]         sentinel_code;

  logic [BOUND_W-1:0] low_bound, high_bound;
  logic [1:0]         code;
  logic               last;

  logic [31:0] rd_lo [EW];
  logic [31:0] rd_hi [EW];

  logic [5:0]         pop_lo [PW];
  logic [5:0]         pop_hi [PW];
  logic [5:0]         pop_lo_c [PW];
  logic [5:0]         pop_hi_c [PW];
  logic [BOUND_W-1:0] count_lo, count_hi, count_lo_c, count_hi_c;
  logic               sent_lo, sent_hi;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [BOUND_W-1:0] cur_lo, cur_hi;
  logic [BOUND_W-1:0] chunk_lo, chunk_hi, chunk_sent;
  logic [AW-1:0]      addr_lo, addr_hi;
  logic [BOUND_W-1:0] sum_lo, sum_hi;
  logic               take_search;
  logic               result_load;
  logic               bounds_load;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      text_length <= BOUND_W'(1);
      sentinel_position <= '0;
      sentinel_code <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEXT_LENGTH: text_length <= cfg_data;
        CFG_SENTINEL_POS: sentinel_position <= cfg_data;
        CFG_SENTINEL_CODE: sentinel_code <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---- issue: apply query start and address both bounds
  always_comb begin
    cur_lo = q_head.start ? '0 : low_bound;
    cur_hi = q_head.start ? text_length : high_bound;
    chunk_lo = cur_lo >> CB;
    chunk_hi = cur_hi >> CB;
    addr_lo = chunk_lo[AW-1:0];
    addr_hi = chunk_hi[AW-1:0];
    wr_addr = AW'(q_head.entry);
  end

  // one bank per word of an entry, two read ports each
  for (genvar b = 0; b < EW; b++) begin : g_bank
    logic [31:0] mem [ENTRIES];
    always_ff @(posedge clk) begin
      if (wr_en && ({29'd0, q_head.sel} == 32'(b))) begin
        mem[wr_addr] <= q_head.data;
      end
      rd_lo[b] <= mem[addr_lo];
      rd_hi[b] <= mem[addr_hi];
    end
  end

  // ---- match stage: masked compare against both planes, popcount per word, count select and sentinel check
  always_comb begin
    int unsigned r_lo, r_hi;
    logic [5:0]  n_lo, n_hi;
    logic [31:0] keep_lo, keep_hi;
    logic [31:0] want0, want1;
    r_lo = 32'(low_bound[CB-1:0]);
    r_hi = 32'(high_bound[CB-1:0]);
    want0 = {32{code[0]}};
    want1 = {32{code[1]}};
    for (int w = 0; w < PW; w++) begin
      if (r_lo >= 32'(32 * w + 32)) begin
        n_lo = 6'd32;
      end else if (r_lo > 32'(32 * w)) begin
        n_lo = 6'(r_lo - 32'(32 * w));
      end else begin
        n_lo = '0;
      end
      if (r_hi >= 32'(32 * w + 32)) begin
        n_hi = 6'd32;
      end else if (r_hi > 32'(32 * w)) begin
        n_hi = 6'(r_hi - 32'(32 * w));
      end else begin
        n_hi = '0;
      end
      // position p sits at bit 31 - p%32, so keep the top n bits
      keep_lo = ~(32'hFFFF_FFFF >> n_lo);
      keep_hi = ~(32'hFFFF_FFFF >> n_hi);
      pop_lo_c[w] = popcount32(keep_lo & ~(rd_lo[w] ^ want0) & ~(rd_lo[PW + w] ^ want1));
      pop_hi_c[w] = popcount32(keep_hi & ~(rd_hi[w] ^ want0) & ~(rd_hi[PW + w] ^ want1));
    end
    count_lo_c = '0;
    count_hi_c = '0;
    for (int c = 0; c < 4; c++) begin
      if (code == 2'(c)) begin
        count_lo_c = rd_lo[2 * PW + c][BOUND_W-1:0];
        count_hi_c = rd_hi[2 * PW + c][BOUND_W-1:0];
      end
    end
    chunk_sent = sentinel_position >> CB;
  end

  always_ff @(posedge clk) begin
    if (state == ST_MATCH) begin
      pop_lo <= pop_lo_c;
      pop_hi <= pop_hi_c;
      count_lo <= count_lo_c;
      count_hi <= count_hi_c;
      sent_lo <= ((low_bound >> CB) == chunk_sent) && (code == sentinel_code) &&
                 (low_bound > sentinel_position);
      sent_hi <= ((high_bound >> CB) == chunk_sent) && (code == sentinel_code) &&
                 (high_bound > sentinel_position);
    end
  end

  // ---- sum stage, wraps to the bound width
  always_comb begin
    sum_lo = count_lo - BOUND_W'(sent_lo);
    sum_hi = count_hi - BOUND_W'(sent_hi);
    for (int w = 0; w < PW; w++) begin
      sum_lo = sum_lo + BOUND_W'(pop_lo[w]);
      sum_hi = sum_hi + BOUND_W'(pop_hi[w]);
    end
  end

  // ---- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    wr_en = 1'b0;
    take_search = 1'b0;
    result_load = 1'b0;
    bounds_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.kind == OP_LOAD) begin
            wr_en = 1'b1;
          end else begin
            take_search = 1'b1;
            state_next = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        // hold while a previous interval still waits at the output
        if (!(last && m_tvalid && !m_tready)) begin
          bounds_load = 1'b1;
          result_load = last;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bound <= '0;
      high_bound <= '0;
    end else if (take_search) begin
      low_bound <= cur_lo;
      high_bound <= cur_hi;
    end else if (bounds_load) begin
      low_bound <= sum_lo;
      high_bound <= sum_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (take_search) begin
      code <= q_head.code;
      last <= q_head.last;
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      m_tdata <= {4'd0, sum_hi, sum_lo};
    end
  end

  assign stat.busy = (state != ST_IDLE);
  assign stat.result_load = result_load;

endmodule

// File: rtl/fm_index_backward_search.sv
// FM-index backward search over a DNA alphabet.
// Input stream: tuser selects the item kind. A load item writes one 32-bit index
// word (entry_index, word_select, word_data); a search item carries one query
// character, last character first, with query_start in tdata and query_end on tlast.
// Each search symbol applies one LF step to both interval bounds; on query_end the
// interval {interval_high, interval_low} leaves on the output stream.
// Configuration: cfg_write with cfg_index 0 text_length, 1 sentinel_position,
// 2 sentinel_code; write only while the block is idle.
// A load item writes its word as it leaves the queue; a search symbol passes index read
// (registered memory), masked popcount, then the sum that closes the bound loop.
// The engine takes no new item until that sum is done; a result reaches m_tvalid via the output register.
// A 4-deep queue sits between input decode and the search engine, so input
// transfers continue while a symbol is worked on or a result waits.
// When the receiver stalls, the result is held; a further end symbol waits in
// its last stage and the queue backs up to s_tready.
// Reset clears bounds, queue and output and sets text_length to 1; the index
// memory is not cleared and must be loaded before use.
// ENTRIES and CHUNK must be powers of two; the block itself does not enforce this.
module fm_index_backward_search import fmbs_pkg::*; #(
  parameter int ENTRIES = 65536,
  parameter int CHUNK = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // entry_index[15:0], word_select[18:16], word_data[50:19],
                                // symbol[58:51], query_start[59], zero fill
  input  logic        s_tuser,  // func
  input  logic        s_tlast,  // query_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // interval_low[21:0], interval_high[43:22], zero fill
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [21:0] cfg_data
);

  logic       q_push;
  op_t        q_in;
  logic       q_full;
  logic       q_valid;
  op_t        q_head;
  logic       q_pop;
  back_stat_t stat;

  fmbs_front #(
    .ENTRIES(ENTRIES),
    .CHUNK(CHUNK)
  ) u_front (
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .q_full(q_full),
    .push(q_push),
    .item(q_in)
  );

  fmbs_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_item(q_in),
    .full(q_full),
    .valid(q_valid),
    .head(q_head),
    .pop(q_pop)
  );

  fmbs_back #(
    .ENTRIES(ENTRIES),
    .CHUNK(CHUNK)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_valid(q_valid),
    .q_head(q_head),
    .q_pop(q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .stat(stat)
  );

`ifndef SYNTH
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stat.result_load |-> !(m_tvalid && !m_tready))
    else $error("result overwrites one not yet taken");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(stat.result_load))
    else $error("output valid without a finished search");

  a_idle_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !stat.busy)
    else $error("queue popped while a symbol is in flight");
`endif

endmodule
